[rtl/preemptive_priority_scheduler_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the preemptive priority scheduler
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication
`define PSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/pss_pkg.sv]
// ----------------------------------------------------------------------------
// pss_pkg
// Shared constants and types of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pss_pkg;

	localparam int BURST_W     = 16;
	localparam int SLOT_PORT_W = 4;

	localparam logic MODE_ARRIVE = 1'b0;
	localparam logic MODE_TICK   = 1'b1;

	typedef struct packed {
		logic arrive;
		logic wb;
		logic clr;
	} pss_cmd_t;

endpackage

[rtl/pss_cell.sv]
// ----------------------------------------------------------------------------
// pss_cell
// One task slot: holds the slot record and passes the best candidate seen so
// far on to the next cell every cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pss_cell import pss_pkg::*; #(
	parameter int SLOT_W    = 4,
	parameter int PRIO_BITS = 8,
	parameter int TIME_BITS = 16,
	parameter int IDX       = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pss_cmd_t             cmd,
	input  logic [SLOT_W-1:0]    arr_slot,
	input  logic [PRIO_BITS-1:0] arr_prio,
	input  logic [BURST_W-1:0]   arr_burst,
	input  logic [TIME_BITS-1:0] now,
	input  logic [SLOT_W-1:0]    wb_slot,
	input  logic [BURST_W-1:0]   wb_rem,
	input  logic                 wb_started,
	input  logic [TIME_BITS-1:0] wb_first,
	input  logic [SLOT_W-1:0]    clr_slot,
	input  logic                 cur_valid,
	input  logic [SLOT_W-1:0]    cur_slot,
	input  logic                 in_found,
	input  logic [PRIO_BITS-1:0] in_prio,
	input  logic [SLOT_W-1:0]    in_slot,
	input  logic [BURST_W-1:0]   in_rem,
	input  logic [BURST_W-1:0]   in_burst,
	input  logic [TIME_BITS-1:0] in_arr,
	input  logic [TIME_BITS-1:0] in_first,
	input  logic                 in_started,
	output logic                 out_found,
	output logic [PRIO_BITS-1:0] out_prio,
	output logic [SLOT_W-1:0]    out_slot,
	output logic [BURST_W-1:0]   out_rem,
	output logic [BURST_W-1:0]   out_burst,
	output logic [TIME_BITS-1:0] out_arr,
	output logic [TIME_BITS-1:0] out_first,
	output logic                 out_started
);

	logic                 ready_q;
	logic                 started_q;
	logic [PRIO_BITS-1:0] prio_q;
	logic [BURST_W-1:0]   rem_q;
	logic [BURST_W-1:0]   burst_q;
	logic [TIME_BITS-1:0] arr_q;
	logic [TIME_BITS-1:0] first_q;
	logic [SLOT_W-1:0]    my_slot;
	logic                 hit_arr;
	logic                 hit_wb;
	logic                 hit_clr;
	logic                 take;

	logic                 found_q;
	logic [PRIO_BITS-1:0] w_prio_q;
	logic [SLOT_W-1:0]    w_slot_q;
	logic [BURST_W-1:0]   w_rem_q;
	logic [BURST_W-1:0]   w_burst_q;
	logic [TIME_BITS-1:0] w_arr_q;
	logic [TIME_BITS-1:0] w_first_q;
	logic                 w_started_q;

	assign my_slot = SLOT_W'(IDX);
	assign hit_arr = cmd.arrive && (arr_slot == my_slot) && !ready_q;
	assign hit_wb  = cmd.wb && (wb_slot == my_slot);
	assign hit_clr = cmd.clr && (clr_slot == my_slot);

	assign take = ready_q && !(cur_valid && (cur_slot == my_slot)) &&
		(!in_found || (prio_q < in_prio));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q   <= 1'b0;
			started_q <= 1'b0;
		end else if (hit_arr) begin
			ready_q   <= 1'b1;
			started_q <= 1'b0;
		end else if (hit_clr) begin
			ready_q   <= 1'b0;
			started_q <= 1'b0;
		end else if (hit_wb) begin
			started_q <= wb_started;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_arr) begin
			prio_q  <= arr_prio;
			rem_q   <= arr_burst;
			burst_q <= arr_burst;
			arr_q   <= now;
			first_q <= '0;
		end else if (hit_wb) begin
			rem_q   <= wb_rem;
			first_q <= wb_first;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else begin
			found_q <= take || in_found;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			w_prio_q    <= prio_q;
			w_slot_q    <= my_slot;
			w_rem_q     <= rem_q;
			w_burst_q   <= burst_q;
			w_arr_q     <= arr_q;
			w_first_q   <= first_q;
			w_started_q <= started_q;
		end else begin
			w_prio_q    <= in_prio;
			w_slot_q    <= in_slot;
			w_rem_q     <= in_rem;
			w_burst_q   <= in_burst;
			w_arr_q     <= in_arr;
			w_first_q   <= in_first;
			w_started_q <= in_started;
		end
	end

	assign out_found   = found_q;
	assign out_prio    = w_prio_q;
	assign out_slot    = w_slot_q;
	assign out_rem     = w_rem_q;
	assign out_burst   = w_burst_q;
	assign out_arr     = w_arr_q;
	assign out_first   = w_first_q;
	assign out_started = w_started_q;

endmodule

[rtl/pss_ctrl.sv]
// ----------------------------------------------------------------------------
// pss_ctrl
// Request handshake, sweep sequencer, running-task record, commit of each
// tick and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "preemptive_priority_scheduler_unit_defines.svh"

module pss_ctrl import pss_pkg::*; #(
	parameter int SLOTS     = 16,
	parameter int SLOT_W    = 4,
	parameter int PRIO_BITS = 8,
	parameter int TIME_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   mode,
	input  logic [SLOT_PORT_W-1:0] task_slot,
	input  logic [BURST_W-1:0]     burst,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   running_valid,
	output logic [SLOT_PORT_W-1:0] running_slot,
	output logic                   finished,
	output logic [TIME_BITS-1:0]   completion_time,
	output logic [TIME_BITS-1:0]   turnaround,
	output logic [TIME_BITS-1:0]   waiting,
	output logic [TIME_BITS-1:0]   first_run_time,
	output pss_cmd_t               cmd,
	output logic [SLOT_W-1:0]      arr_slot,
	output logic [TIME_BITS-1:0]   now,
	output logic [SLOT_W-1:0]      wb_slot,
	output logic [BURST_W-1:0]     wb_rem,
	output logic                   wb_started,
	output logic [TIME_BITS-1:0]   wb_first,
	output logic [SLOT_W-1:0]      clr_slot,
	output logic                   cur_valid,
	output logic [SLOT_W-1:0]      cur_slot,
	input  logic                   w_found,
	input  logic [PRIO_BITS-1:0]   w_prio,
	input  logic [SLOT_W-1:0]      w_slot,
	input  logic [BURST_W-1:0]     w_rem,
	input  logic [BURST_W-1:0]     w_burst,
	input  logic [TIME_BITS-1:0]   w_arr,
	input  logic [TIME_BITS-1:0]   w_first,
	input  logic                   w_started
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SWEEP  = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;
	localparam logic [1:0] ST_FIN    = 2'd3;

	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
	localparam int WW = (TIME_BITS > BURST_W) ? TIME_BITS : BURST_W;

	logic [1:0]           state_q;
	logic [SLOT_W-1:0]    cnt_q;
	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] nxt_q;

	logic                 cur_valid_q;
	logic [SLOT_W-1:0]    cur_slot_q;
	logic [PRIO_BITS-1:0] cur_prio_q;
	logic [BURST_W-1:0]   cur_rem_q;
	logic [BURST_W-1:0]   cur_burst_q;
	logic [TIME_BITS-1:0] cur_arr_q;
	logic [TIME_BITS-1:0] cur_first_q;
	logic                 cur_started_q;

	logic                 commit;
	logic                 accept;
	logic                 in_range;
	logic                 sw;
	logic                 run;
	logic                 fin;
	logic [SLOT_W-1:0]    r_slot;
	logic [BURST_W-1:0]   r_rem;
	logic [BURST_W-1:0]   r_burst;
	logic [TIME_BITS-1:0] r_arr;
	logic [TIME_BITS-1:0] r_first;
	logic                 r_started;
	logic [BURST_W-1:0]   new_rem;
	logic [TIME_BITS-1:0] new_first;
	logic [TIME_BITS-1:0] tat;

	logic                 run_s1;
	logic                 fin_s1;
	logic [SLOT_W-1:0]    slot_s1;
	logic [TIME_BITS-1:0] ct_s1;
	logic [TIME_BITS-1:0] tat_s1;
	logic [BURST_W-1:0]   burst_s1;
	logic [TIME_BITS-1:0] first_s1;

	logic [WW-1:0]        tat_x;
	logic [WW-1:0]        burst_x;
	logic [TIME_BITS-1:0] wt;
	logic                 load;

	logic                   out_valid_q;
	logic                   run_q;
	logic [SLOT_PORT_W-1:0] slot_q;
	logic                   fin_q;
	logic [TIME_BITS-1:0]   ct_q;
	logic [TIME_BITS-1:0]   tat_q;
	logic [TIME_BITS-1:0]   wt_q;
	logic [TIME_BITS-1:0]   first_q;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign commit   = (state_q == ST_COMMIT);
	assign in_range = (int'(task_slot) < SLOTS);

	// pick against the running task, then run one unit
	always_comb begin
		sw        = w_found && (!cur_valid_q || (w_prio < cur_prio_q));
		run       = sw || cur_valid_q;
		r_slot    = sw ? w_slot    : cur_slot_q;
		r_rem     = sw ? w_rem     : cur_rem_q;
		r_burst   = sw ? w_burst   : cur_burst_q;
		r_arr     = sw ? w_arr     : cur_arr_q;
		r_first   = sw ? w_first   : cur_first_q;
		r_started = sw ? w_started : cur_started_q;
		new_rem   = (r_rem != '0) ? r_rem - BURST_W'(1) : '0;
		new_first = r_started ? r_first : now_q;
		fin       = run && (new_rem == '0);
		tat       = (nxt_q >= r_arr) ? nxt_q - r_arr : '0;
	end

	always_comb begin
		cmd.arrive = accept && (mode == MODE_ARRIVE) && (burst != '0) && in_range;
		cmd.wb     = commit && sw && cur_valid_q;
		cmd.clr    = commit && fin;
	end

	assign arr_slot   = SLOT_W'(task_slot);
	assign now        = now_q;
	assign wb_slot    = cur_slot_q;
	assign wb_rem     = cur_rem_q;
	assign wb_started = cur_started_q;
	assign wb_first   = cur_first_q;
	assign clr_slot   = r_slot;
	assign cur_valid  = cur_valid_q;
	assign cur_slot   = cur_slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (mode == MODE_TICK)) begin
						state_q <= ST_SWEEP;
						cnt_q   <= '0;
					end
				end
				ST_SWEEP: begin
					cnt_q <= cnt_q + SLOT_W'(1);
					if (cnt_q == SLOT_W'(SLOTS - 1)) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// advance time, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			nxt_q <= TIME_BITS'(1);
		end else if (commit) begin
			now_q <= nxt_q;
			if (nxt_q != TIME_MAX) begin
				nxt_q <= nxt_q + TIME_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			cur_slot_q  <= '0;
		end else if (commit && run) begin
			cur_valid_q <= !fin;
			cur_slot_q  <= fin ? '0 : r_slot;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && run && !fin) begin
			if (sw) begin
				cur_prio_q <= w_prio;
			end
			cur_rem_q     <= new_rem;
			cur_burst_q   <= r_burst;
			cur_arr_q     <= r_arr;
			cur_first_q   <= new_first;
			cur_started_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			run_s1   <= run;
			fin_s1   <= fin;
			slot_s1  <= r_slot;
			ct_s1    <= nxt_q;
			tat_s1   <= tat;
			burst_s1 <= r_burst;
			first_s1 <= new_first;
		end
	end

	assign tat_x   = WW'(tat_s1);
	assign burst_x = WW'(burst_s1);
	assign wt      = (tat_x >= burst_x) ? TIME_BITS'(tat_x - burst_x) : '0;
	assign load    = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_q   <= run_s1;
			slot_q  <= run_s1 ? SLOT_PORT_W'(slot_s1) : '0;
			fin_q   <= fin_s1;
			ct_q    <= fin_s1 ? ct_s1    : '0;
			tat_q   <= fin_s1 ? tat_s1   : '0;
			wt_q    <= fin_s1 ? wt       : '0;
			first_q <= fin_s1 ? first_s1 : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign running_valid   = run_q;
	assign running_slot    = slot_q;
	assign finished        = fin_q;
	assign completion_time = ct_q;
	assign turnaround      = tat_q;
	assign waiting         = wt_q;
	assign first_run_time  = first_q;

	`PSS_ASSERT_NOW(a_wb_clr_apart, cmd.wb && cmd.clr, wb_slot != clr_slot, "wb and clear hit one slot")
	`PSS_ASSERT_NOW(a_switch_other, commit && sw && cur_valid_q, w_slot != cur_slot_q, "switch to running slot")
	`PSS_ASSERT_NOW(a_fin_runs, out_valid_q && fin_q, run_q, "finished without a running task")
	`PSS_ASSERT_NEXT(a_time_mono, commit, now_q >= $past(now_q), "time went backward")

endmodule

[rtl/preemptive_priority_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit
// Tick-driven preemptive priority scheduler over a chain of task slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready. mode 0 registers a task in task_slot
//   with priority_req and burst (zero burst, occupied slot or slot beyond the
//   table is dropped); mode 1 is one tick of time.
//   Each tick yields one result on out_valid/out_ready: the slot that ran,
//   and on completion its completion, turnaround, waiting and first-run times.
//   An arrive request yields no result.
//   A tick passes through the accept, a sweep in which the candidate travels
//   the cell chain, one commit, and the forming of the result.
//   The result register holds while the receiver stalls; arrive requests are
//   still taken while no tick is in progress, and a further tick waits in its
//   final state until the result register frees.
//   Reset clears all slot ready flags, the running task and the time counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module preemptive_priority_scheduler_unit import pss_pkg::*; #(
	parameter int SLOTS     = 16,
	parameter int PRIO_BITS = 8,
	parameter int TIME_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   mode,
	input  logic [SLOT_PORT_W-1:0] task_slot,
	input  logic [PRIO_BITS-1:0]   priority_req,
	input  logic [BURST_W-1:0]     burst,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   running_valid,
	output logic [SLOT_PORT_W-1:0] running_slot,
	output logic                   finished,
	output logic [TIME_BITS-1:0]   completion_time,
	output logic [TIME_BITS-1:0]   turnaround,
	output logic [TIME_BITS-1:0]   waiting,
	output logic [TIME_BITS-1:0]   first_run_time
);

	localparam int SLOT_W = $clog2(SLOTS);

	pss_cmd_t             cmd;
	logic [SLOT_W-1:0]    arr_slot;
	logic [TIME_BITS-1:0] now;
	logic [SLOT_W-1:0]    wb_slot;
	logic [BURST_W-1:0]   wb_rem;
	logic                 wb_started;
	logic [TIME_BITS-1:0] wb_first;
	logic [SLOT_W-1:0]    clr_slot;
	logic                 cur_valid;
	logic [SLOT_W-1:0]    cur_slot;

	logic [SLOTS:0]       ch_found;
	logic [SLOTS:0]       ch_started;
	logic [PRIO_BITS-1:0] ch_prio  [SLOTS+1];
	logic [SLOT_W-1:0]    ch_slot  [SLOTS+1];
	logic [BURST_W-1:0]   ch_rem   [SLOTS+1];
	logic [BURST_W-1:0]   ch_burst [SLOTS+1];
	logic [TIME_BITS-1:0] ch_arr   [SLOTS+1];
	logic [TIME_BITS-1:0] ch_first [SLOTS+1];

	assign ch_found[0]   = 1'b0;
	assign ch_started[0] = 1'b0;
	assign ch_prio[0]    = '0;
	assign ch_slot[0]    = '0;
	assign ch_rem[0]     = '0;
	assign ch_burst[0]   = '0;
	assign ch_arr[0]     = '0;
	assign ch_first[0]   = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		pss_cell #(
			.SLOT_W    (SLOT_W),
			.PRIO_BITS (PRIO_BITS),
			.TIME_BITS (TIME_BITS),
			.IDX       (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.arr_slot    (arr_slot),
			.arr_prio    (priority_req),
			.arr_burst   (burst),
			.now         (now),
			.wb_slot     (wb_slot),
			.wb_rem      (wb_rem),
			.wb_started  (wb_started),
			.wb_first    (wb_first),
			.clr_slot    (clr_slot),
			.cur_valid   (cur_valid),
			.cur_slot    (cur_slot),
			.in_found    (ch_found[i]),
			.in_prio     (ch_prio[i]),
			.in_slot     (ch_slot[i]),
			.in_rem      (ch_rem[i]),
			.in_burst    (ch_burst[i]),
			.in_arr      (ch_arr[i]),
			.in_first    (ch_first[i]),
			.in_started  (ch_started[i]),
			.out_found   (ch_found[i+1]),
			.out_prio    (ch_prio[i+1]),
			.out_slot    (ch_slot[i+1]),
			.out_rem     (ch_rem[i+1]),
			.out_burst   (ch_burst[i+1]),
			.out_arr     (ch_arr[i+1]),
			.out_first   (ch_first[i+1]),
			.out_started (ch_started[i+1])
		);
	end

	pss_ctrl #(
		.SLOTS     (SLOTS),
		.SLOT_W    (SLOT_W),
		.PRIO_BITS (PRIO_BITS),
		.TIME_BITS (TIME_BITS)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.mode            (mode),
		.task_slot       (task_slot),
		.burst           (burst),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.running_valid   (running_valid),
		.running_slot    (running_slot),
		.finished        (finished),
		.completion_time (completion_time),
		.turnaround      (turnaround),
		.waiting         (waiting),
		.first_run_time  (first_run_time),
		.cmd             (cmd),
		.arr_slot        (arr_slot),
		.now             (now),
		.wb_slot         (wb_slot),
		.wb_rem          (wb_rem),
		.wb_started      (wb_started),
		.wb_first        (wb_first),
		.clr_slot        (clr_slot),
		.cur_valid       (cur_valid),
		.cur_slot        (cur_slot),
		.w_found         (ch_found[SLOTS]),
		.w_prio          (ch_prio[SLOTS]),
		.w_slot          (ch_slot[SLOTS]),
		.w_rem           (ch_rem[SLOTS]),
		.w_burst         (ch_burst[SLOTS]),
		.w_arr           (ch_arr[SLOTS]),
		.w_first         (ch_first[SLOTS]),
		.w_started       (ch_started[SLOTS])
	);

endmodule
